### rtl/core/pdts_pkg.sv
// Shared types, constants and calendar functions for the packed date converter.
package pdts_pkg;

	// Field widths.
	localparam int STAMP_W = 40;
	localparam int DAY_W   = 21;
	localparam int TIME_W  = 20;
	localparam int SEC_W   = 32;
	localparam int DAYS_W  = 15;
	localparam int PROD_W  = 53;

	// Calendar constants.
	localparam longint DAY_SPLIT        = 1000000;
	localparam int     SECONDS_PER_DAY  = 86400;
	localparam int     FIRST_YEAR       = 16;
	localparam int     COMMON_YEAR_DAYS = 365;
	localparam int     SIXTY            = 60;

	// Reciprocals for exact division by 100 and by 10000 of values below 2^32.
	localparam logic [31:0] RECIP_100  = 32'h51EB_851F;
	localparam int          SHIFT_100  = 37;
	localparam logic [31:0] RECIP_10K  = 32'hD1B7_1759;
	localparam int          SHIFT_10K  = 45;

	// Reciprocal of one million scaled by 2^46, applied to the stamp without its low
	// 14 bits; the estimate it gives is the quotient or one less.
	localparam int          HI_SHIFT   = 14;
	localparam int          HI_W       = STAMP_W - HI_SHIFT;
	localparam int          RECIP_1M_W = 27;
	localparam logic [26:0] RECIP_1M   = 27'd70368744;
	localparam int          SHIFT_1M   = 32;
	localparam int          EST_PROD_W = HI_W + RECIP_1M_W;
	localparam int          REM_W      = TIME_W + 1;

	// Pipeline and queue sizes.
	localparam int FRONT_STAGES = 3;
	localparam int MID_DEPTH    = 4;
	localparam int MID_AW       = $clog2(MID_DEPTH);
	localparam int BACK_STAGES  = 4;
	localparam int OUT_DEPTH    = 4;
	localparam int OUT_AW       = $clog2(OUT_DEPTH);
	localparam int ITEM_CAPACITY = FRONT_STAGES + MID_DEPTH + BACK_STAGES + OUT_DEPTH;

	// Word handed from the splitting front end to the calendar back end.
	typedef struct packed {
		logic [DAY_W-1:0]  day_part;
		logic [TIME_W-1:0] time_part;
	} mid_word_t;

	// Days in all whole years from the first year up to the year before yy.
	function automatic logic [DAYS_W-1:0] year_days(input logic [6:0] yy);
		logic [6:0]  n;
		logic [16:0] acc;
		n = (yy > 7'(FIRST_YEAR)) ? 7'(yy - 7'(FIRST_YEAR)) : 7'd0;
		acc = 17'(n) * 17'(COMMON_YEAR_DAYS) + 17'((8'(n) + 8'd3) >> 2);
		return acc[DAYS_W-1:0];
	endfunction

	// Days in the months elapsed before mm; February counts 29 in a leap year.
	function automatic logic [8:0] month_days(input logic [6:0] mm, input logic leap);
		logic [8:0] base;
		unique case (mm)
			7'd0, 7'd1: base = 9'd0;
			7'd2:       base = 9'd31;
			7'd3:       base = 9'd59;
			7'd4:       base = 9'd90;
			7'd5:       base = 9'd120;
			7'd6:       base = 9'd151;
			7'd7:       base = 9'd181;
			7'd8:       base = 9'd212;
			7'd9:       base = 9'd243;
			7'd10:      base = 9'd273;
			7'd11:      base = 9'd304;
			default:    base = 9'd334;
		endcase
		return base + 9'((leap && (mm >= 7'd3)) ? 1 : 0);
	endfunction

endpackage

### rtl/core/pdts_front.sv
// Front end: accepts packed stamps and splits them into day and time parts.
module pdts_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic [pdts_pkg::STAMP_W-1:0]    packed_stamp,
	output logic                            full,
	output logic                            mid_wr,
	output pdts_pkg::mid_word_t             mid_word,
	input  logic                            mid_full
);
	import pdts_pkg::*;

	logic                  adv;
	logic [EST_PROD_W-1:0] est_prod;
	logic [REM_W-1:0]      rem_raw;
	logic                  take;

	logic                  vld_s1;
	logic [DAY_W-1:0]      est_s1;
	logic [REM_W-1:0]      low_s1;
	logic                  vld_s2;
	logic [DAY_W-1:0]      est_s2;
	logic [REM_W-1:0]      low_s2;
	logic [REM_W-1:0]      sub_s2;
	logic                  vld_s3;
	logic [DAY_W-1:0]      quo_s3;
	logic [TIME_W-1:0]     rem_s3;

	// The whole front end moves together unless its last word cannot leave.
	assign adv    = !(vld_s3 && mid_full);
	assign full   = !adv;
	assign mid_wr = vld_s3 && !mid_full;
	assign mid_word.day_part  = quo_s3;
	assign mid_word.time_part = rem_s3;

	// Quotient estimate by one million from the high stamp bits.
	assign est_prod = EST_PROD_W'(packed_stamp[STAMP_W-1:HI_SHIFT]) * EST_PROD_W'(RECIP_1M);

	// The remainder of the estimate is below two million, so its low bits are enough.
	assign rem_raw = low_s2 - sub_s2;
	assign take    = rem_raw >= REM_W'(DAY_SPLIT);

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= push;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Estimate, back-multiply, then one correction step.
	always_ff @(posedge clk) begin
		if (adv) begin
			est_s1 <= est_prod[SHIFT_1M+DAY_W-1:SHIFT_1M];
			low_s1 <= packed_stamp[REM_W-1:0];
			est_s2 <= est_s1;
			low_s2 <= low_s1;
			sub_s2 <= REM_W'(REM_W'(est_s1) * REM_W'(DAY_SPLIT));
			quo_s3 <= take ? est_s2 + 1'b1 : est_s2;
			rem_s3 <= take ? TIME_W'(rem_raw - REM_W'(DAY_SPLIT)) : rem_raw[TIME_W-1:0];
		end
	end

endmodule

### rtl/core/pdts_mid_queue.sv
// Short queue that decouples the splitting front end from the calendar back end.
module pdts_mid_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  pdts_pkg::mid_word_t wr_word,
	output logic                full,
	input  logic                rd_en,
	output pdts_pkg::mid_word_t rd_word,
	output logic                empty
);
	import pdts_pkg::*;

	mid_word_t         mem_q [MID_DEPTH];
	logic [MID_AW-1:0] wr_ptr_q;
	logic [MID_AW-1:0] rd_ptr_q;
	logic [MID_AW:0]   cnt_q;

	assign full    = cnt_q == (MID_AW+1)'(MID_DEPTH);
	assign empty   = cnt_q == '0;
	assign rd_word = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_word;
		end
	end

endmodule

### rtl/core/pdts_back.sv
// Back end: decodes the decimal fields, counts days and seconds, and queues results.
module pdts_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pdts_pkg::mid_word_t          mid_word,
	input  logic                         mid_empty,
	output logic                         mid_rd,
	output logic                         empty,
	input  logic                         pop,
	output logic [pdts_pkg::SEC_W-1:0]   seconds_count
);
	import pdts_pkg::*;

	logic en;
	logic out_full;

	// Stage 1: reciprocal products.
	logic              v_s1;
	logic [DAY_W-1:0]  day_s1;
	logic [TIME_W-1:0] tim_s1;
	logic [13:0]       dq100_s1;
	logic [6:0]        dq10k_s1;
	logic [13:0]       tq100_s1;
	logic [6:0]        tq10k_s1;
	logic [PROD_W-1:0] dp100;
	logic [PROD_W-1:0] dp10k;
	logic [PROD_W-1:0] tp100;
	logic [PROD_W-1:0] tp10k;

	// Stage 2: decimal fields.
	logic              v_s2;
	logic [6:0]        dd_s2;
	logic [6:0]        mm_s2;
	logic [6:0]        yy_s2;
	logic [6:0]        hh_s2;
	logic [6:0]        mn_s2;
	logic [6:0]        ss_s2;
	logic [DAY_W-1:0]  dd_full;
	logic [13:0]       mm_full;
	logic [TIME_W-1:0] ss_full;
	logic [13:0]       mn_full;

	// Stage 3: day count and hour-minute count.
	logic              v_s3;
	logic [DAYS_W-1:0] days_s3;
	logic [12:0]       hm_s3;
	logic [6:0]        ss_s3;

	// Stage 4: seconds from days and from the time of day.
	logic              v_s4;
	logic [SEC_W-1:0]  day_sec_s4;
	logic [18:0]       tod_sec_s4;

	// Result queue.
	logic [SEC_W-1:0]  out_mem_q [OUT_DEPTH];
	logic [OUT_AW-1:0] out_wr_q;
	logic [OUT_AW-1:0] out_rd_q;
	logic [OUT_AW:0]   out_cnt_q;
	logic              out_wr;
	logic              out_rd;
	logic [SEC_W:0]    total;

	// The pipeline moves together unless the finished word cannot enter the result queue.
	assign en     = !(v_s4 && out_full);
	assign mid_rd = en && !mid_empty;

	assign dp100 = PROD_W'(mid_word.day_part)  * PROD_W'(RECIP_100);
	assign dp10k = PROD_W'(mid_word.day_part)  * PROD_W'(RECIP_10K);
	assign tp100 = PROD_W'(mid_word.time_part) * PROD_W'(RECIP_100);
	assign tp10k = PROD_W'(mid_word.time_part) * PROD_W'(RECIP_10K);

	assign dd_full = day_s1 - DAY_W'(DAY_W'(dq100_s1) * DAY_W'(100));
	assign mm_full = dq100_s1 - 14'(14'(dq10k_s1) * 14'd100);
	assign ss_full = tim_s1 - TIME_W'(TIME_W'(tq100_s1) * TIME_W'(100));
	assign mn_full = tq100_s1 - 14'(14'(tq10k_s1) * 14'd100);

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= mid_rd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (en) begin
			day_s1   <= mid_word.day_part;
			tim_s1   <= mid_word.time_part;
			dq100_s1 <= dp100[SHIFT_100+13:SHIFT_100];
			dq10k_s1 <= dp10k[SHIFT_10K+6:SHIFT_10K];
			tq100_s1 <= tp100[SHIFT_100+13:SHIFT_100];
			tq10k_s1 <= tp10k[SHIFT_10K+6:SHIFT_10K];

			dd_s2 <= dd_full[6:0];
			mm_s2 <= mm_full[6:0];
			yy_s2 <= (dq10k_s1 >= 7'd100) ? 7'(dq10k_s1 - 7'd100) : dq10k_s1;
			hh_s2 <= tq10k_s1;
			mn_s2 <= mn_full[6:0];
			ss_s2 <= ss_full[6:0];

			days_s3 <= year_days(yy_s2) + DAYS_W'(month_days(mm_s2, yy_s2[1:0] == 2'b00))
				+ DAYS_W'(dd_s2);
			hm_s3   <= 13'(13'(hh_s2) * 13'(SIXTY)) + 13'(mn_s2);
			ss_s3   <= ss_s2;

			day_sec_s4 <= SEC_W'(SEC_W'(days_s3) * SEC_W'(SECONDS_PER_DAY));
			tod_sec_s4 <= 19'(19'(hm_s3) * 19'(SIXTY)) + 19'(ss_s3);
		end
	end

	// Result queue control.
	assign total         = (SEC_W+1)'(day_sec_s4) + (SEC_W+1)'(tod_sec_s4);
	assign out_full      = out_cnt_q == (OUT_AW+1)'(OUT_DEPTH);
	assign empty         = out_cnt_q == '0;
	assign out_wr        = v_s4 && !out_full;
	assign out_rd        = pop && !empty;
	assign seconds_count = out_mem_q[out_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= '0;
			out_rd_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (out_wr) begin
				out_wr_q <= out_wr_q + 1'b1;
			end
			if (out_rd) begin
				out_rd_q <= out_rd_q + 1'b1;
			end
			if (out_wr && !out_rd) begin
				out_cnt_q <= out_cnt_q + 1'b1;
			end else if (out_rd && !out_wr) begin
				out_cnt_q <= out_cnt_q - 1'b1;
			end
		end
	end

	// Result storage; the sum is masked to 32 bits.
	always_ff @(posedge clk) begin
		if (out_wr) begin
			out_mem_q[out_wr_q] <= total[SEC_W-1:0];
		end
	end

endmodule

### rtl/core/packed_date_to_seconds.sv
// Top level of the packed date to seconds converter.
// A producer writes YYMMDDhhmmss stamps, held as one binary number in a 40-bit word,
// with push while full is low; every accepted word yields exactly one result word.
// Results come out in order as from a queue: seconds_count is valid while empty is
// low and is taken with pop. Digits above YY are dropped as century.
// A word passes through the front end, the middle queue, the back end and the
// result queue. When nothing stalls, one word is taken per cycle: a 3-stage
// front end divides by one million with a reciprocal multiply and one correction
// step, and a 4-stage back end with reciprocal multipliers decodes the fields
// and counts days and seconds.
// A four-word queue sits between the two halves and a four-word result queue
// sits at the output, so a stalled receiver first fills the result queue; then the
// back end holds, the middle queue fills and full rises to stop the producer.
// No word is lost or repeated under any pattern of push and pop.
// Reset clears all valid bits and queue pointers; the block is ready as soon as
// reset is released.
module packed_date_to_seconds (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [pdts_pkg::STAMP_W-1:0]   packed_stamp,
	output logic                           empty,
	input  logic                           pop,
	output logic [pdts_pkg::SEC_W-1:0]     seconds_count
);
	import pdts_pkg::*;

	logic      mid_wr;
	logic      mid_rd;
	logic      mid_full;
	logic      mid_empty;
	mid_word_t front_word;
	mid_word_t back_word;

	// Front end: splits stamps into day and time parts.
	pdts_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.packed_stamp (packed_stamp),
		.full         (full),
		.mid_wr       (mid_wr),
		.mid_word     (front_word),
		.mid_full     (mid_full)
	);

	// Queue between the two halves.
	pdts_mid_queue u_mid (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_wr),
		.wr_word (front_word),
		.full    (mid_full),
		.rd_en   (mid_rd),
		.rd_word (back_word),
		.empty   (mid_empty)
	);

	// Back end: calendar arithmetic and result queue.
	pdts_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.mid_word      (back_word),
		.mid_empty     (mid_empty),
		.mid_rd        (mid_rd),
		.empty         (empty),
		.pop           (pop),
		.seconds_count (seconds_count)
	);

endmodule

### rtl/core/pdts_checker.sv
// Port-level checker for the packed date converter, bound to the top level.
module pdts_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           push,
	input logic                           full,
	input logic [pdts_pkg::STAMP_W-1:0]   packed_stamp,
	input logic                           empty,
	input logic                           pop,
	input logic [pdts_pkg::SEC_W-1:0]     seconds_count
);
	import pdts_pkg::*;

	localparam int CNT_W = $clog2(ITEM_CAPACITY + 1);

	logic             in_acc;
	logic             out_acc;
	logic [CNT_W-1:0] pending_q;

	assign in_acc  = push && !full;
	assign out_acc = pop && !empty;

	// Words accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// A result is shown only for a word that was accepted and not yet delivered.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pending_q != '0)
		else $error("result shown with no word outstanding");

	// The block never holds more words than its stages and queues can store.
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= CNT_W'(ITEM_CAPACITY))
		else $error("more words outstanding than the block can hold");

	// A shown result stays until it is taken.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result withdrawn before it was taken");

	// A shown result does not change while the receiver stalls.
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(seconds_count))
		else $error("result changed while stalled");

endmodule

bind packed_date_to_seconds pdts_checker u_pdts_checker (.*);
